// ===== src/uer_pkg.sv =====
// Package of shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

    localparam int unsigned CountWidth = 16;
    localparam int unsigned DistWidth  = 11;
    localparam int unsigned StatWidth  = 2;
    localparam int unsigned PhaseWidth = 2;
    localparam int unsigned ScaleWidth = 15;
    localparam int unsigned ProdWidth  = CountWidth + ScaleWidth;
    localparam int unsigned FracBits   = 20;

    // Centimetres per microsecond tick, 0.01715 in Q0.20, truncated.
    localparam logic [ScaleWidth-1:0] CM_PER_TICK_Q20 = 15'd17983;

    localparam logic [PhaseWidth-1:0] PH_IDLE = 2'd0;
    localparam logic [PhaseWidth-1:0] PH_TRIG = 2'd1;
    localparam logic [PhaseWidth-1:0] PH_WAIT = 2'd2;
    localparam logic [PhaseWidth-1:0] PH_MEAS = 2'd3;

    localparam logic [StatWidth-1:0] ST_OK        = 2'd0;
    localparam logic [StatWidth-1:0] ST_NO_RISE   = 2'd1;
    localparam logic [StatWidth-1:0] ST_LONG_ECHO = 2'd2;

    localparam logic REG_TRIGGER_TICKS = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    localparam logic [CountWidth-1:0] TRIGGER_TICKS_RESET = 16'd1000;
    localparam logic [CountWidth-1:0] TIMEOUT_TICKS_RESET = 16'd20000;

    typedef struct packed {
        logic [PhaseWidth-1:0] phase;
        logic [CountWidth-1:0] tick_count;
    } ranger_state_t;

    typedef struct packed {
        logic [CountWidth-1:0] trigger_ticks;
        logic [CountWidth-1:0] timeout_ticks;
    } ranger_cfg_t;

    typedef struct packed {
        logic                 trigger_level;
        logic                 busy_res;
        logic                 done_res;
        logic [DistWidth-1:0] distance;
        logic [StatWidth-1:0] status;
    } ranger_result_t;

endpackage

// ===== src/uer_cfg.sv =====
// APB-style configuration registers of the ultrasonic echo ranger.
module uer_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output uer_pkg::ranger_cfg_t cfg
);

    logic [uer_pkg::CountWidth-1:0] trigger_ticks_reg, trigger_ticks_next;
    logic [uer_pkg::CountWidth-1:0] timeout_ticks_reg, timeout_ticks_next;
    logic                           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        trigger_ticks_next = trigger_ticks_reg;
        timeout_ticks_next = timeout_ticks_reg;
        if (wr_en) begin
            case (paddr[2])
                uer_pkg::REG_TRIGGER_TICKS: trigger_ticks_next = pwdata[15:0];
                uer_pkg::REG_TIMEOUT_TICKS: timeout_ticks_next = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trigger_ticks_reg <= uer_pkg::TRIGGER_TICKS_RESET;
            timeout_ticks_reg <= uer_pkg::TIMEOUT_TICKS_RESET;
        end else begin
            trigger_ticks_reg <= trigger_ticks_next;
            timeout_ticks_reg <= timeout_ticks_next;
        end
    end

    always_comb begin
        case (paddr[2])
            uer_pkg::REG_TRIGGER_TICKS: prdata = {16'd0, trigger_ticks_reg};
            uer_pkg::REG_TIMEOUT_TICKS: prdata = {16'd0, timeout_ticks_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign cfg.trigger_ticks = trigger_ticks_reg;
    assign cfg.timeout_ticks = timeout_ticks_reg;

endmodule

// ===== src/uer_step.sv =====
// Per-tick phase logic: next state and result of one tick of the ranger.
module uer_step (
    input  uer_pkg::ranger_state_t  state,
    input  uer_pkg::ranger_cfg_t    cfg,
    input  logic                    start_req,
    input  logic                    echo_level,
    output uer_pkg::ranger_state_t  state_next,
    output uer_pkg::ranger_result_t result
);

    logic [uer_pkg::CountWidth-1:0] count_inc;
    logic [uer_pkg::ProdWidth-1:0]  product;

    assign count_inc = state.tick_count + 16'd1;
    assign product   = uer_pkg::ProdWidth'(state.tick_count) *
                       uer_pkg::ProdWidth'(uer_pkg::CM_PER_TICK_Q20);

    always_comb begin
        state_next           = state;
        result.trigger_level = 1'b0;
        result.busy_res      = 1'b0;
        result.done_res      = 1'b0;
        result.distance      = '0;
        result.status        = uer_pkg::ST_OK;
        case (state.phase)
            uer_pkg::PH_IDLE: begin
                if (start_req) begin
                    result.trigger_level = 1'b1;
                    result.busy_res      = 1'b1;
                    if (16'd1 >= cfg.trigger_ticks) begin
                        state_next.phase      = uer_pkg::PH_WAIT;
                        state_next.tick_count = '0;
                    end else begin
                        state_next.phase      = uer_pkg::PH_TRIG;
                        state_next.tick_count = 16'd1;
                    end
                end
            end
            uer_pkg::PH_TRIG: begin
                result.trigger_level = 1'b1;
                result.busy_res      = 1'b1;
                if (count_inc >= cfg.trigger_ticks) begin
                    state_next.phase      = uer_pkg::PH_WAIT;
                    state_next.tick_count = '0;
                end else begin
                    state_next.tick_count = count_inc;
                end
            end
            uer_pkg::PH_WAIT: begin
                if (echo_level) begin
                    // The rise tick already counts as one tick of pulse.
                    if (16'd1 >= cfg.timeout_ticks) begin
                        result.done_res       = 1'b1;
                        result.status         = uer_pkg::ST_LONG_ECHO;
                        state_next.phase      = uer_pkg::PH_IDLE;
                        state_next.tick_count = '0;
                    end else begin
                        result.busy_res       = 1'b1;
                        state_next.phase      = uer_pkg::PH_MEAS;
                        state_next.tick_count = 16'd1;
                    end
                end else if (count_inc >= cfg.timeout_ticks) begin
                    result.done_res       = 1'b1;
                    result.status         = uer_pkg::ST_NO_RISE;
                    state_next.phase      = uer_pkg::PH_IDLE;
                    state_next.tick_count = '0;
                end else begin
                    result.busy_res       = 1'b1;
                    state_next.tick_count = count_inc;
                end
            end
            uer_pkg::PH_MEAS: begin
                if (echo_level) begin
                    if (count_inc >= cfg.timeout_ticks) begin
                        result.done_res       = 1'b1;
                        result.status         = uer_pkg::ST_LONG_ECHO;
                        state_next.phase      = uer_pkg::PH_IDLE;
                        state_next.tick_count = '0;
                    end else begin
                        result.busy_res       = 1'b1;
                        state_next.tick_count = count_inc;
                    end
                end else begin
                    result.done_res       = 1'b1;
                    result.distance       =
                        product[uer_pkg::FracBits +: uer_pkg::DistWidth];
                    state_next.phase      = uer_pkg::PH_IDLE;
                    state_next.tick_count = '0;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== src/ultrasonic_echo_ranger_top.sv =====
// Top level of the ultrasonic echo ranger: input register, phase logic, result register.
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_start_req, s_echo_level
//  m_        out        m_valid / m_ready   trigger, busy, done, distance, status
//  apb       in         psel / penable      paddr, pwdata, prdata
//
// One transaction is taken every cycle while s_ready is high; its result passes through the
// input register and then the result register before it is offered on m_.
// The input register and the result register form a two-stage pipeline, and the phase
// and tick count update once per transaction as it moves into the result register.
// Reset returns the ranger to idle with a zero tick count and reset register values.
// A stall on m_ready holds the result and lets one more transaction wait in the input stage.
module ultrasonic_echo_ranger_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_start_req,
    input  logic        s_echo_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_trigger_level,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic [10:0] m_distance,
    output logic [1:0]  m_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    uer_pkg::ranger_cfg_t    cfg;
    uer_pkg::ranger_state_t  state_reg, state_next;
    uer_pkg::ranger_result_t step_result;
    uer_pkg::ranger_result_t result_reg;

    logic in_valid_reg, in_valid_next;
    logic in_start_reg, in_echo_reg;
    logic out_valid_reg, out_valid_next;
    logic out_free, fire, s_take;

    uer_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    uer_step u_step (
        .state      (state_reg),
        .cfg        (cfg),
        .start_req  (in_start_reg),
        .echo_level (in_echo_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_take   = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_free ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            state_reg.phase      <= uer_pkg::PH_IDLE;
            state_reg.tick_count <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_start_reg <= s_start_req;
            in_echo_reg  <= s_echo_level;
        end
        if (fire) begin
            result_reg <= step_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_trigger_level = result_reg.trigger_level;
    assign m_busy_res      = result_reg.busy_res;
    assign m_done_res      = result_reg.done_res;
    assign m_distance      = result_reg.distance;
    assign m_status        = result_reg.status;

`ifndef SYNTHESIS
    // A finished measurement is never reported as still busy.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done and busy both set");

    // A non-zero distance only comes with a successful finish.
    a_distance_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_distance != 11'd0) |-> m_done_res && (m_status == uer_pkg::ST_OK))
        else $error("distance outside an ok finish");

    // A timeout status is only reported on a done tick.
    a_status_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != uer_pkg::ST_OK) |-> m_done_res)
        else $error("status without done");

    // The tick counter is clear whenever the ranger is idle.
    a_idle_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == uer_pkg::PH_IDLE |-> state_reg.tick_count == '0)
        else $error("tick count not clear in idle");

    // The ranger state moves only when a transaction passes into the result register.
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(state_reg))
        else $error("state changed without a transaction");
`endif

endmodule
